FILE: hw/rtl/twis_pkg.sv
`default_nettype none
package twis_pkg;

  localparam int NODE_COUNT_DEF = 256;
  localparam int ALPHABET_DEF   = 26;
  localparam int LETTER_W       = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // result handed from the walk sequencer to the output register
  typedef struct packed {
    logic vld;
    logic found;
    logic pool_full;
  } twis_res_t;

endpackage
`default_nettype wire

FILE: hw/rtl/twis_ram.sv
`default_nettype none
module twis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/twis_ctrl.sv
`default_nettype none
module twis_ctrl #(
  parameter int NODE_COUNT = twis_pkg::NODE_COUNT_DEF,
  parameter int ALPHABET   = twis_pkg::ALPHABET_DEF,
  localparam int NW        = $clog2(NODE_COUNT),
  localparam int DEPTH_C   = NODE_COUNT * ALPHABET,
  localparam int AW        = $clog2(DEPTH_C)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic                          in_opcode,
  input  wire logic [twis_pkg::LETTER_W-1:0] in_letter,
  input  wire logic                          in_last_char,
  output logic                               in_stall,
  input  wire logic                          out_free,
  output twis_pkg::twis_res_t                res,
  output logic                               c_we,
  output logic      [AW-1:0]                 c_waddr,
  output logic      [NW-1:0]                 c_wdata,
  output logic                               c_re,
  output logic      [AW-1:0]                 c_raddr,
  input  wire logic [NW-1:0]                 c_rdata,
  output logic                               m_we,
  output logic      [NW-1:0]                 m_waddr,
  output logic      [0:0]                    m_wdata,
  output logic                               m_re,
  output logic      [NW-1:0]                 m_raddr,
  input  wire logic [0:0]                    m_rdata
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_LOOK  = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  localparam logic [NW:0]   NODE_LIM = (NW+1)'(NODE_COUNT);
  localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH_C - 1);

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [NW-1:0] cur_r, cur_nxt;
  logic [NW:0]   free_r, free_nxt;
  logic          failed_r, failed_nxt;
  logic          pool_hit_r, pool_hit_nxt;
  logic          op_r, op_nxt;
  logic          last_r, last_nxt;
  logic          skip_r, skip_nxt;
  logic [AW-1:0] slot_r, slot_nxt;
  logic          res_found_r, res_found_nxt;
  logic          res_full_r, res_full_nxt;
  logic          sel_mark_r, sel_mark_nxt;

  logic          accept, bad_code, has_child, is_ins, pool_out, alloc, fail_now, ok;
  logic          hit_pool;
  logic [NW-1:0] new_node;
  logic [AW-1:0] slot_addr;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign bad_code  = 32'(in_letter) >= 32'(ALPHABET);
  assign slot_addr = AW'(32'(cur_r) * 32'(ALPHABET) + 32'(in_letter));

  assign has_child = (c_rdata != '0);
  assign is_ins    = (op_r == twis_pkg::OP_INSERT);
  assign pool_out  = (free_r >= NODE_LIM);
  assign alloc     = !skip_r && !has_child && is_ins && !pool_out;
  assign fail_now  = skip_r || (!has_child && (!is_ins || pool_out));
  assign ok        = !fail_now;
  assign hit_pool  = pool_hit_r || (!skip_r && !has_child && is_ins && pool_out);
  assign new_node  = has_child ? c_rdata : free_r[NW-1:0];

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    cur_nxt       = cur_r;
    free_nxt      = free_r;
    failed_nxt    = failed_r;
    pool_hit_nxt  = pool_hit_r;
    op_nxt        = op_r;
    last_nxt      = last_r;
    skip_nxt      = skip_r;
    slot_nxt      = slot_r;
    res_found_nxt = res_found_r;
    res_full_nxt  = res_full_r;
    sel_mark_nxt  = sel_mark_r;
    res           = '0;
    c_we          = 1'b0;
    c_waddr       = slot_r;
    c_wdata       = free_r[NW-1:0];
    c_re          = 1'b0;
    c_raddr       = slot_addr;
    m_we          = 1'b0;
    m_waddr       = new_node;
    m_wdata       = 1'(last_r && is_ins);
    m_re          = 1'b0;
    m_raddr       = new_node;

    case (state_r)
      S_CLEAR: begin
        c_we    = 1'b1;
        c_waddr = clr_addr_r;
        c_wdata = '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          c_re      = !bad_code && !failed_r;
          op_nxt    = in_opcode;
          last_nxt  = in_last_char;
          skip_nxt  = failed_r || bad_code;
          slot_nxt  = slot_addr;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        c_we     = alloc;
        m_we     = alloc || (ok && last_r && is_ins);
        free_nxt = alloc ? free_r + (NW+1)'(1) : free_r;
        if (!last_r) begin
          cur_nxt      = ok ? new_node : cur_r;
          failed_nxt   = fail_now;
          pool_hit_nxt = hit_pool;
          state_nxt    = S_IDLE;
        end else begin
          cur_nxt      = '0;
          failed_nxt   = 1'b0;
          pool_hit_nxt = 1'b0;
          if (!is_ins && ok) begin
            m_re         = 1'b1;
            sel_mark_nxt = 1'b1;
            res_full_nxt = 1'b0;
            state_nxt    = S_FIN;
          end else begin
            sel_mark_nxt  = 1'b0;
            res_found_nxt = is_ins && ok;
            res_full_nxt  = is_ins && !ok && hit_pool;
            if (out_free) begin
              res.vld       = 1'b1;
              res.found     = is_ins && ok;
              res.pool_full = is_ins && !ok && hit_pool;
              state_nxt     = S_IDLE;
            end else begin
              state_nxt = S_FIN;
            end
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          res.vld       = 1'b1;
          res.found     = sel_mark_r ? m_rdata[0] : res_found_r;
          res.pool_full = res_full_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
      cur_r      <= '0;
      free_r     <= (NW+1)'(1);
      failed_r   <= 1'b0;
      pool_hit_r <= 1'b0;
      sel_mark_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      cur_r      <= cur_nxt;
      free_r     <= free_nxt;
      failed_r   <= failed_nxt;
      pool_hit_r <= pool_hit_nxt;
      sel_mark_r <= sel_mark_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    last_r      <= last_nxt;
    skip_r      <= skip_nxt;
    slot_r      <= slot_nxt;
    res_found_r <= res_found_nxt;
    res_full_r  <= res_full_nxt;
  end

  a_no_child_rw: assert property (@(posedge clk) disable iff (!rst_n)
    !(c_we && c_re))
    else $error("child memory read and written in one cycle");

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= NODE_LIM)
    else $error("free node pointer past pool end");

  a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_LOOK)
    else $error("accepted request did not start a lookup");

  a_alloc_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOK && c_we) |=> free_r == $past(free_r) + (NW+1)'(1))
    else $error("allocation did not advance free pointer");

  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res.vld |-> out_free)
    else $error("result issued into a full output register");

endmodule
`default_nettype wire

FILE: hw/rtl/trie_word_insert_search.sv
// Trie dictionary of upper-case words, fed one letter per request.
// Input channel (in_valid/in_stall): in_opcode selects insert or search, in_letter is the
// letter code (A = 0), in_last_char marks the final letter of a word. A letter code at or
// beyond the alphabet fails the rest of its word.
// Result channel (out_valid/out_stall): one result per final letter. out_found is set when
// a search hits a stored word or an insert stored its word; out_pool_full is set when an
// insert ran out of free nodes.
// Each letter waits in the lookup state for the child pointer read from the child memory,
// and the next letter is taken only when that lookup is done; the final letter of a search
// whose walk reached a node adds a read of the word-end memory. out_valid is registered: the
// result is loaded from the lookup state, or from the finish state after a word-end read.
// Reset: after rst_n the child memory is swept to zero, NODE_COUNT*ALPHABET cycles (6656
// by default), with in_stall high. The free pointer restarts at node 1.
// Receiver stall: a result waits in the output register; the next letter is still taken,
// and the block holds only when a second result is due while the first is not yet taken.
`default_nettype none
module trie_word_insert_search #(
  parameter int NODE_COUNT = twis_pkg::NODE_COUNT_DEF,
  parameter int ALPHABET   = twis_pkg::ALPHABET_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_opcode,
  input  wire logic [twis_pkg::LETTER_W-1:0] in_letter,
  input  wire logic                          in_last_char,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_found,
  output logic                               out_pool_full
);

  localparam int NW      = $clog2(NODE_COUNT);
  localparam int DEPTH_C = NODE_COUNT * ALPHABET;
  localparam int AW      = $clog2(DEPTH_C);

  logic                c_we, c_re;
  logic [AW-1:0]       c_waddr, c_raddr;
  logic [NW-1:0]       c_wdata, c_rdata;
  logic                m_we, m_re;
  logic [NW-1:0]       m_waddr, m_raddr;
  logic [0:0]          m_wdata, m_rdata;
  logic                out_free;
  twis_pkg::twis_res_t res;

  logic out_valid_r, out_valid_nxt;
  logic out_found_r, out_pool_full_r;

  // child pointers, one entry per node and letter; zero means no child
  twis_ram #(
    .WIDTH (NW),
    .DEPTH (DEPTH_C)
  ) u_child_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .re    (c_re),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  // word-end marks, written when a node is allocated or an insert ends on it, so no sweep is needed
  twis_ram #(
    .WIDTH (1),
    .DEPTH (NODE_COUNT)
  ) u_mark_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .re    (m_re),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  twis_ctrl #(
    .NODE_COUNT (NODE_COUNT),
    .ALPHABET   (ALPHABET)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_opcode    (in_opcode),
    .in_letter    (in_letter),
    .in_last_char (in_last_char),
    .in_stall     (in_stall),
    .out_free     (out_free),
    .res          (res),
    .c_we         (c_we),
    .c_waddr      (c_waddr),
    .c_wdata      (c_wdata),
    .c_re         (c_re),
    .c_raddr      (c_raddr),
    .c_rdata      (c_rdata),
    .m_we         (m_we),
    .m_waddr      (m_waddr),
    .m_wdata      (m_wdata),
    .m_re         (m_re),
    .m_raddr      (m_raddr),
    .m_rdata      (m_rdata)
  );

  // the output register can take a result when empty or being drained this cycle
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.vld) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // load the payload only with a new result; hold it while stalled
  always_ff @(posedge clk) begin
    if (res.vld) begin
      out_found_r     <= res.found;
      out_pool_full_r <= res.pool_full;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_found     = out_found_r;
  assign out_pool_full = out_pool_full_r;

endmodule
`default_nettype wire
